// File: src/assert_macros.svh
// ----------------------------------------------------------------------------
// assert_macros.svh
// Assertion macros used by the filter RTL.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// property must hold on every clock outside reset
`define FIRC_CHECK(lbl, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);

// expression must never be true outside reset
`define FIRC_NEVER(lbl, expr, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) !(expr)) else $error(msg);

`endif

// File: src/firc_pkg.sv
// ----------------------------------------------------------------------------
// firc_pkg
// Types and constants of the circular-history FIR filter.
// ----------------------------------------------------------------------------
package firc_pkg;

    localparam int MAX_TAPS   = 95;
    localparam int HIST_DEPTH = MAX_TAPS - 1;
    localparam int IDX_W      = $clog2(MAX_TAPS);
    localparam int HADDR_W    = $clog2(HIST_DEPTH);
    localparam int TAP_W      = 7;
    localparam int SAMPLE_W   = 16;
    localparam int ACC_W      = 32;
    localparam logic [TAP_W-1:0] TAP_RESET = TAP_W'(MAX_TAPS);

    typedef enum logic [1:0] {
        OP_FILTER  = 2'd0,
        OP_COEF    = 2'd1,
        OP_RESTART = 2'd2,
        OP_CLEAR   = 2'd3
    } op_t;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_WALK,
        ST_DRAIN,
        ST_EMIT
    } state_t;

    typedef struct packed {
        logic valid;
        logic last;
        logic use_data;
        logic coef_live;
        logic hist_live;
    } mac_issue_t;

endpackage

// File: src/firc_ram.sv
// ----------------------------------------------------------------------------
// firc_ram
// Simple dual-port synchronous RAM, one write and one registered read port.
// ----------------------------------------------------------------------------
module firc_ram #(
    parameter int WIDTH = 16,
    parameter int DEPTH = 95
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

// File: src/firc_mac.sv
// ----------------------------------------------------------------------------
// firc_mac
// Pipelined multiply-accumulate: operand select, product, negated x4 sum.
// ----------------------------------------------------------------------------
module firc_mac (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                start,
    input  firc_pkg::mac_issue_t                issue,
    input  logic signed [firc_pkg::SAMPLE_W-1:0] coef_rdata,
    input  logic signed [firc_pkg::SAMPLE_W-1:0] hist_rdata,
    input  logic signed [firc_pkg::SAMPLE_W-1:0] sample,
    output logic                                done,
    output logic        [firc_pkg::ACC_W-1:0]    acc
);

    import firc_pkg::*;

    mac_issue_t                 s1_reg;
    logic                       s2_valid_reg;
    logic                       s2_last_reg;
    logic                       done_reg;
    logic signed [ACC_W-1:0]    prod_reg;
    logic signed [ACC_W-1:0]    prod_next;
    logic        [ACC_W-1:0]    acc_reg;
    logic        [ACC_W-1:0]    acc_next;
    logic signed [SAMPLE_W-1:0] op_c;
    logic signed [SAMPLE_W-1:0] op_s;

    always_comb
    begin
        op_c = s1_reg.coef_live ? coef_rdata : '0;
        if (s1_reg.use_data)
        begin
            op_s = sample;
        end
        else
        begin
            op_s = s1_reg.hist_live ? hist_rdata : '0;
        end
        prod_next = op_c * op_s;
        acc_next  = acc_reg - {prod_reg[ACC_W-3:0], 2'b00};
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_reg       <= '0;
            s2_valid_reg <= 1'b0;
            s2_last_reg  <= 1'b0;
            done_reg     <= 1'b0;
        end
        else
        begin
            s1_reg       <= issue;
            s2_valid_reg <= s1_reg.valid;
            s2_last_reg  <= s1_reg.valid && s1_reg.last;
            done_reg     <= s2_valid_reg && s2_last_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        prod_reg <= prod_next;
        if (start)
        begin
            acc_reg <= '0;
        end
        else if (s2_valid_reg)
        begin
            acc_reg <= acc_next;
        end
    end

    assign done = done_reg;
    assign acc  = acc_reg;

endmodule

// File: src/fir_filter_circular_unit.sv
// ----------------------------------------------------------------------------
// fir_filter_circular_unit
// FIR filter over a circular sample history, coefficients and history in RAM.
// ----------------------------------------------------------------------------
// Command channel (cmd_valid/cmd_stall) carries opcode, coef_index and data.
// Filter commands return one transaction on the result channel
// (res_valid/res_stall, field filtered); other opcodes return nothing.
// Coefficient write, restart and clear complete in the acceptance cycle.
// A filter command walks the taps one per cycle through the coefficient and
// history RAM read ports into a single multiplier (tap_count taken within 1
// to 95); each product passes the registered RAM reads and the product
// register into the accumulator, whose sum is loaded into the output register
// once the walk has drained. A new command is accepted once the result has
// moved to the output register, so one filter ends before the next starts.
// cfg_we/cfg_wdata write tap_count and must only be used while idle.
// Reset clears tap_count to 95, position to zero and every entry's valid
// flag, so both stores read as zero without a clearing pass.
// When the receiver stalls, the result is held in the output register; the
// next command may still be accepted and runs until its own result is ready,
// then waits for the register to free.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module fir_filter_circular_unit (
    input  logic                                 clk,
    input  logic                                 rst_n,
    input  logic                                 cfg_we,
    input  logic [firc_pkg::TAP_W-1:0]           cfg_wdata,
    input  logic                                 cmd_valid,
    output logic                                 cmd_stall,
    input  firc_pkg::op_t                        opcode,
    input  logic [firc_pkg::TAP_W-1:0]           coef_index,
    input  logic signed [firc_pkg::SAMPLE_W-1:0] data,
    output logic                                 res_valid,
    input  logic                                 res_stall,
    output logic signed [firc_pkg::ACC_W-1:0]    filtered
);

    import firc_pkg::*;

    state_t                     state_reg;
    state_t                     state_next;
    logic [TAP_W-1:0]           tap_count_reg;
    logic [IDX_W-1:0]           len_reg;
    logic [IDX_W-1:0]           len_next;
    logic [IDX_W-1:0]           k_reg;
    logic [HADDR_W-1:0]         p_reg;
    logic [HADDR_W-1:0]         p_inc;
    logic [HADDR_W-1:0]         pos_reg;
    logic [HADDR_W-1:0]         pos_eff;
    logic [HADDR_W-1:0]         pos_inc;
    logic [MAX_TAPS-1:0]        coef_vld_reg;
    logic [HIST_DEPTH-1:0]      hist_vld_reg;
    logic signed [SAMPLE_W-1:0] data_reg;
    logic                       res_valid_reg;
    logic [ACC_W-1:0]           filtered_reg;

    logic                       cmd_acc;
    logic                       res_free;
    logic                       mac_start;
    logic                       emit_go;
    logic                       coef_we;
    logic                       hist_we;
    mac_issue_t                 issue;
    logic signed [SAMPLE_W-1:0] coef_rdata;
    logic signed [SAMPLE_W-1:0] hist_rdata;
    logic                       mac_done;
    logic [ACC_W-1:0]           mac_acc;

    assign cmd_acc  = cmd_valid && !cmd_stall;
    assign res_free = !res_valid_reg || !res_stall;

    always_comb
    begin
        priority if (tap_count_reg == '0)
        begin
            len_next = '0;
        end
        else if (int'(tap_count_reg) > MAX_TAPS)
        begin
            len_next = IDX_W'(MAX_TAPS - 1);
        end
        else
        begin
            len_next = IDX_W'(tap_count_reg - TAP_W'(1));
        end
        pos_eff = (int'(pos_reg) >= int'(len_next)) ? '0 : pos_reg;
        p_inc   = (int'(p_reg) + 1 >= int'(len_reg)) ? '0 : p_reg + HADDR_W'(1);
        pos_inc = (int'(pos_reg) + 1 >= int'(len_reg)) ? '0 : pos_reg + HADDR_W'(1);
    end

    // next state
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (cmd_acc && opcode == OP_FILTER)
                begin
                    state_next = ST_WALK;
                end
            end
            ST_WALK:
            begin
                if (k_reg == len_reg)
                begin
                    state_next = ST_DRAIN;
                end
            end
            ST_DRAIN:
            begin
                if (mac_done)
                begin
                    state_next = ST_EMIT;
                end
            end
            ST_EMIT:
            begin
                if (res_free)
                begin
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // outputs
    always_comb
    begin
        cmd_stall       = (state_reg != ST_IDLE);
        mac_start       = 1'b0;
        emit_go         = 1'b0;
        issue           = '0;
        issue.use_data  = (k_reg == len_reg);
        issue.last      = (k_reg == len_reg);
        issue.coef_live = coef_vld_reg[k_reg];
        issue.hist_live = hist_vld_reg[p_reg];
        unique case (state_reg)
            ST_IDLE:  mac_start   = cmd_acc && (opcode == OP_FILTER);
            ST_WALK:  issue.valid = 1'b1;
            ST_DRAIN: ;
            ST_EMIT:  emit_go     = res_free;
            default:  ;
        endcase
        coef_we = cmd_acc && (opcode == OP_COEF) && (int'(coef_index) < MAX_TAPS);
        hist_we = emit_go && (len_reg != '0);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            tap_count_reg <= TAP_RESET;
            len_reg       <= '0;
            k_reg         <= '0;
            p_reg         <= '0;
            pos_reg       <= '0;
            coef_vld_reg  <= '0;
            hist_vld_reg  <= '0;
            res_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            if (cfg_we)
            begin
                tap_count_reg <= cfg_wdata;
            end
            if (cmd_acc)
            begin
                unique case (opcode)
                    OP_FILTER:
                    begin
                        len_reg <= len_next;
                        k_reg   <= '0;
                        p_reg   <= pos_eff;
                        pos_reg <= pos_eff;
                    end
                    OP_COEF:
                    begin
                        if (coef_we)
                        begin
                            coef_vld_reg[IDX_W'(coef_index)] <= 1'b1;
                        end
                    end
                    OP_RESTART:
                    begin
                        pos_reg <= '0;
                    end
                    OP_CLEAR:
                    begin
                        pos_reg      <= '0;
                        coef_vld_reg <= '0;
                        hist_vld_reg <= '0;
                    end
                    default: ;
                endcase
            end
            if (issue.valid)
            begin
                k_reg <= k_reg + IDX_W'(1);
                p_reg <= p_inc;
            end
            if (emit_go)
            begin
                pos_reg <= (len_reg == '0) ? '0 : pos_inc;
            end
            if (hist_we)
            begin
                hist_vld_reg[pos_reg] <= 1'b1;
            end
            if (emit_go)
            begin
                res_valid_reg <= 1'b1;
            end
            else if (!res_stall)
            begin
                res_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd_acc)
        begin
            data_reg <= data;
        end
        if (emit_go)
        begin
            filtered_reg <= mac_acc;
        end
    end

    firc_ram #(
        .WIDTH (SAMPLE_W),
        .DEPTH (MAX_TAPS)
    ) u_coef_ram (
        .clk   (clk),
        .we    (coef_we),
        .waddr (IDX_W'(coef_index)),
        .wdata (data),
        .raddr (k_reg),
        .rdata (coef_rdata)
    );

    firc_ram #(
        .WIDTH (SAMPLE_W),
        .DEPTH (HIST_DEPTH)
    ) u_hist_ram (
        .clk   (clk),
        .we    (hist_we),
        .waddr (pos_reg),
        .wdata (data_reg),
        .raddr (p_reg),
        .rdata (hist_rdata)
    );

    firc_mac u_mac (
        .clk        (clk),
        .rst_n      (rst_n),
        .start      (mac_start),
        .issue      (issue),
        .coef_rdata (coef_rdata),
        .hist_rdata (hist_rdata),
        .sample     (data_reg),
        .done       (mac_done),
        .acc        (mac_acc)
    );

    assign res_valid = res_valid_reg;
    assign filtered  = filtered_reg;

    `FIRC_CHECK(a_done_in_drain, mac_done |-> state_reg == ST_DRAIN, "mac done outside drain")
    `FIRC_CHECK(a_walk_bound, state_reg == ST_WALK |-> k_reg <= len_reg, "tap walk overran")
    `FIRC_NEVER(a_pos_range, int'(pos_reg) >= HIST_DEPTH, "position beyond history")
    `FIRC_CHECK(a_emit_result, emit_go |=> res_valid_reg, "result not presented")

endmodule

// File: sim/fir_filter_circular_unit_tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// fir_filter_circular_unit_tb
// Self-checking bench for the circular-history FIR filter. A scoreboard keeps
// its own coefficients, sample history and position, predicts each filter
// transaction's result and compares it with the result channel, under random
// source gaps and sink stalls across a range of tap counts.
// ----------------------------------------------------------------------------

class fir_predictor;

    logic signed [firc_pkg::SAMPLE_W-1:0] coef [firc_pkg::MAX_TAPS];
    logic signed [firc_pkg::SAMPLE_W-1:0] hist [firc_pkg::HIST_DEPTH];
    int                                   pos;
    logic [firc_pkg::TAP_W-1:0]           taps = firc_pkg::TAP_RESET;
    logic signed [firc_pkg::ACC_W-1:0]    expected_sums [$];
    int                                   mismatches;

    function void clear_stores();
        foreach (coef[i]) coef[i] = '0;
        foreach (hist[i]) hist[i] = '0;
        pos = 0;
    endfunction

    function int pending();
        return expected_sums.size();
    endfunction

    function void note_command(firc_pkg::op_t op, logic [firc_pkg::TAP_W-1:0] idx,
                               logic signed [firc_pkg::SAMPLE_W-1:0] sample);
        int                                t;
        int                                len;
        int                                p;
        logic signed [firc_pkg::ACC_W-1:0] prod;
        logic [firc_pkg::ACC_W-1:0]        acc;
        case (op)
            firc_pkg::OP_COEF:
                if (idx < firc_pkg::MAX_TAPS) coef[idx] = sample;
            firc_pkg::OP_RESTART:
                pos = 0;
            firc_pkg::OP_CLEAR:
                clear_stores();
            default:
            begin
                t = int'(taps);
                if (t < 1) t = 1;
                if (t > firc_pkg::MAX_TAPS) t = firc_pkg::MAX_TAPS;
                len = t - 1;
                acc = '0;
                if (len == 0)
                begin
                    pos = 0;
                    prod = coef[0] * sample;
                    acc = acc - {prod[29:0], 2'b00};
                end
                else
                begin
                    if (pos >= len) pos = 0;
                    p = pos;
                    for (int k = 0; k < len; k++)
                    begin
                        prod = coef[k] * hist[p];
                        acc = acc - {prod[29:0], 2'b00};
                        p++;
                        if (p >= len) p = 0;
                    end
                    prod = coef[len] * sample;
                    acc = acc - {prod[29:0], 2'b00};
                    hist[pos] = sample;
                    pos++;
                    if (pos >= len) pos = 0;
                end
                expected_sums.push_back(acc);
            end
        endcase
    endfunction

    function void check_result(logic signed [firc_pkg::ACC_W-1:0] actual);
        logic signed [firc_pkg::ACC_W-1:0] want;
        if (expected_sums.size() == 0)
        begin
            $display("%0t: unexpected filtered transaction, expected none, actual %0d",
                     $time, actual);
            mismatches++;
        end
        else
        begin
            want = expected_sums.pop_front();
            if (want !== actual)
            begin
                $display("%0t: filtered mismatch, expected %0d, actual %0d",
                         $time, want, actual);
                mismatches++;
            end
        end
    endfunction

endclass

module fir_filter_circular_unit_tb;

    import firc_pkg::*;

    localparam int SETTLE_CYCLES = 120;

    logic                       clk;
    logic                       rst_n;
    logic                       cfg_we;
    logic [TAP_W-1:0]           cfg_wdata;
    logic                       cmd_valid;
    logic                       cmd_stall;
    op_t                        opcode;
    logic [TAP_W-1:0]           coef_index;
    logic signed [SAMPLE_W-1:0] data;
    logic                       res_valid;
    logic                       res_stall;
    logic signed [ACC_W-1:0]    filtered;

    bit           quiet_run = 1'b0;
    fir_predictor sb = new;

    fir_filter_circular_unit dut (
        .clk        (clk),
        .rst_n      (rst_n),
        .cfg_we     (cfg_we),
        .cfg_wdata  (cfg_wdata),
        .cmd_valid  (cmd_valid),
        .cmd_stall  (cmd_stall),
        .opcode     (opcode),
        .coef_index (coef_index),
        .data       (data),
        .res_valid  (res_valid),
        .res_stall  (res_stall),
        .filtered   (filtered)
    );

    initial clk = 1'b0;

    always
    begin
        #1 clk = 1'b1;
        #1 clk = 1'b0;
    end

    always @(posedge clk)
    begin
        if (rst_n && cmd_valid && !cmd_stall)
            sb.note_command(opcode, coef_index, data);
        if (rst_n && res_valid && !res_stall)
            sb.check_result(filtered);
        if (rst_n && cfg_we)
            sb.taps = cfg_wdata;
    end

    // sink back-pressure in bursts
    initial
    begin
        res_stall = 1'b0;
        forever
        begin
            @(negedge clk);
            if (!quiet_run && $urandom_range(0, 2) == 0)
            begin
                res_stall = 1'b1;
                repeat ($urandom_range(1, 19)) @(negedge clk);
                res_stall = 1'b0;
                repeat ($urandom_range(1, 19)) @(negedge clk);
            end
        end
    end

    initial
    begin
        #2_000_000;
        $display("Regression FAIL");
        $finish;
    end

    function automatic logic signed [SAMPLE_W-1:0] rand_sample();
        case ($urandom_range(0, 19))
            0:       return 16'sh8000;
            1:       return 16'sh7fff;
            2:       return 16'sh0000;
            3:       return 16'shffff;
            default: return SAMPLE_W'($urandom_range(0, 16'hffff));
        endcase
    endfunction

    // called just after a falling edge; returns just after a falling edge
    task automatic send_command(input op_t op, input logic [TAP_W-1:0] idx,
                                input logic signed [SAMPLE_W-1:0] value);
        cmd_valid  = 1'b1;
        opcode     = op;
        coef_index = idx;
        data       = value;
        @(posedge clk);
        while (cmd_stall) @(posedge clk);
        @(negedge clk);
        if (!quiet_run && $urandom_range(0, 3) == 0)
        begin
            cmd_valid = 1'b0;
            repeat ($urandom_range(1, 19)) @(negedge clk);
        end
    endtask

    task automatic settle();
        cmd_valid = 1'b0;
        while (sb.pending() != 0) @(negedge clk);
        repeat (SETTLE_CYCLES) @(negedge clk);
    endtask

    task automatic write_taps(input logic [TAP_W-1:0] setting);
        cfg_we    = 1'b1;
        cfg_wdata = setting;
        @(negedge clk);
        cfg_we    = 1'b0;
    endtask

    task automatic run_phase(input logic [TAP_W-1:0] setting, input int count);
        int               eff;
        int               r;
        logic [TAP_W-1:0] idx;
        settle();
        write_taps(setting);
        eff = int'(setting);
        if (eff < 1) eff = 1;
        if (eff > MAX_TAPS) eff = MAX_TAPS;
        repeat (8) send_command(OP_COEF, TAP_W'($urandom_range(0, eff - 1)), rand_sample());
        repeat (count)
        begin
            r = $urandom_range(0, 99);
            if (r < 56)
                send_command(OP_FILTER, TAP_W'($urandom_range(0, 127)), rand_sample());
            else if (r < 90)
            begin
                if ($urandom_range(0, 6) == 0)
                    idx = TAP_W'($urandom_range(0, 127));
                else
                    idx = TAP_W'($urandom_range(0, eff - 1));
                send_command(OP_COEF, idx, rand_sample());
            end
            else if (r < 97)
                send_command(OP_RESTART, TAP_W'($urandom_range(0, 127)), rand_sample());
            else
                send_command(OP_CLEAR, TAP_W'($urandom_range(0, 127)), rand_sample());
        end
    endtask

    initial
    begin
        logic [TAP_W-1:0] setting;
        int               w;
        rst_n      = 1'b0;
        cfg_we     = 1'b0;
        cfg_wdata  = '0;
        cmd_valid  = 1'b0;
        opcode     = OP_FILTER;
        coef_index = '0;
        data       = '0;
        sb.clear_stores();
        repeat (10) @(negedge clk);
        rst_n = 1'b1;
        @(negedge clk);

        // directed: reset tap count, extremes, ignored slots, wrap of the product
        send_command(OP_FILTER,  7'd0,   16'sh7fff);
        send_command(OP_COEF,    7'd0,   16'sh8000);
        send_command(OP_COEF,    7'd94,  16'sh7fff);
        send_command(OP_COEF,    7'd47,  16'sh8000);
        send_command(OP_COEF,    7'd95,  16'sh1234);
        send_command(OP_COEF,    7'd127, 16'shffff);
        send_command(OP_FILTER,  7'd127, 16'sh8000);
        send_command(OP_FILTER,  7'd0,   16'sh7fff);
        send_command(OP_FILTER,  7'd0,   16'shffff);
        send_command(OP_RESTART, 7'd0,   16'sh0000);
        send_command(OP_FILTER,  7'd0,   16'sh0001);
        send_command(OP_FILTER,  7'd0,   16'sh0000);
        send_command(OP_COEF,    7'd94,  16'sh8000);
        send_command(OP_FILTER,  7'd0,   16'sh8000);
        // history shrinks below the current position
        settle();
        write_taps(7'd3);
        send_command(OP_FILTER,  7'd0,   16'sh0064);
        send_command(OP_FILTER,  7'd0,   -16'sd100);
        // tap count of zero behaves as a single tap
        settle();
        write_taps(7'd0);
        send_command(OP_FILTER,  7'd0,   16'sh8000);
        // tap count above the maximum
        settle();
        write_taps(7'd127);
        send_command(OP_FILTER,  7'd0,   16'sh0005);
        send_command(OP_CLEAR,   7'd127, 16'shffff);
        send_command(OP_FILTER,  7'd0,   16'sh7fff);

        run_phase(7'd95, 70);
        run_phase(7'd1, 70);
        run_phase(7'd2, 70);
        run_phase(7'd127, 70);
        run_phase(7'd0, 70);
        run_phase(7'd3, 70);
        run_phase(7'd96, 70);
        for (int ph = 0; ph < 5; ph++)
        begin
            if (ph >= 3) quiet_run = 1'b1;
            if ($urandom_range(0, 3) == 0)
                setting = TAP_W'($urandom_range(0, 127));
            else
                setting = TAP_W'($urandom_range(1, 16));
            run_phase(setting, 70);
        end

        cmd_valid = 1'b0;
        for (w = 0; w < 20000 && sb.pending() != 0; w++) @(negedge clk);
        repeat (SETTLE_CYCLES) @(negedge clk);
        if (sb.pending() != 0)
        begin
            $display("%0t: %0d filtered transactions never arrived", $time, sb.pending());
            sb.mismatches++;
        end
        if (sb.mismatches == 0)
            $display("Regression PASS");
        else
            $display("Regression FAIL");
        $finish;
    end

endmodule

// File: files.f
+incdir+src
src/firc_pkg.sv
src/firc_ram.sv
src/firc_mac.sv
src/fir_filter_circular_unit.sv
sim/fir_filter_circular_unit_tb.sv
